/* design/tlsu_pkg.sv */
`timescale 1ns / 1ps

package tlsu_pkg;

   // Depth of the queue between the decode front and the execute back.
   localparam int QUEUE_DEPTH = 2;

   // The PC is word aligned before a PC-relative offset is added.
   localparam logic [31:0] PC_ALIGN_MASK = 32'hFFFF_FFFC;

   typedef enum logic [1:0] {
      RK_READ  = 2'd0,
      RK_WRITE = 2'd1,
      RK_WB    = 2'd2,
      RK_ERR   = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      SZ_BYTE = 2'd0,
      SZ_HALF = 2'd1,
      SZ_WORD = 2'd2
   } access_size_type;

   typedef enum logic [2:0] {
      LK_WORD  = 3'd0,
      LK_HALF  = 3'd1,
      LK_BYTE  = 3'd2,
      LK_SBYTE = 3'd3,
      LK_SHALF = 3'd4
   } load_kind_type;

   // One decoded item as it waits in the queue.
   typedef struct packed {
      logic            is_return;
      logic            is_legal;
      logic            is_load;
      access_size_type size;
      load_kind_type   load_kind;
      logic [2:0]      dest;
      logic [31:0]     addr;
      logic [31:0]     data;
   } fe_item_type;

   // Status of the execute back, watched at the top level.
   typedef struct packed {
      logic pending;
      logic load_issued;
      logic load_done;
   } bk_status_type;

endpackage

/* design/tlsu_if.sv */
`timescale 1ns / 1ps

interface tlsu_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] opcode;
   logic [31:0] base_value;
   logic [31:0] index_value;
   logic [31:0] data_value;
   logic [31:0] pc_value;
   logic [31:0] sp_value;
   logic [31:0] read_data;

   modport source (
      output valid, req_type, opcode, base_value, index_value, data_value,
             pc_value, sp_value, read_data,
      input  ready
   );

   modport sink (
      input  valid, req_type, opcode, base_value, index_value, data_value,
             pc_value, sp_value, read_data,
      output ready
   );
endinterface

interface tlsu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] mem_address;
   logic [1:0]  access_size;
   logic [31:0] write_data;
   logic [2:0]  dest_reg;
   logic [31:0] reg_value;

   modport source (
      output valid, result_kind, mem_address, access_size, write_data,
             dest_reg, reg_value,
      input  ready
   );

   modport sink (
      input  valid, result_kind, mem_address, access_size, write_data,
             dest_reg, reg_value,
      output ready
   );
endinterface

/* design/tlsu_front.sv */
`timescale 1ns / 1ps

module tlsu_front (
   tlsu_req_if.sink             req_chan,
   input  logic                 push_ready,
   output logic                 push_valid,
   output tlsu_pkg::fe_item_type push_item
);

   logic [15:0] op;
   logic [4:0]  imm5;
   logic [7:0]  imm8;
   logic [31:0] add_a;
   logic [31:0] add_b;
   logic [31:0] addr_sum;
   tlsu_pkg::fe_item_type item;

   assign op   = req_chan.opcode;
   assign imm5 = op[10:6];
   assign imm8 = op[7:0];

   // The front takes an item whenever the queue has room.
   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign push_item      = item;

   // Operand selection for the single address adder.
   always_comb begin
      add_a = req_chan.base_value;
      add_b = {27'd0, imm5};
      if (op[15:11] == 5'b01001) begin
         add_a = req_chan.pc_value & tlsu_pkg::PC_ALIGN_MASK;
         add_b = {22'd0, imm8, 2'b00};
      end else if (op[15:12] == 4'b0101) begin
         add_b = req_chan.index_value;
      end else if (op[15:13] == 3'b011) begin
         add_b = op[12] ? {27'd0, imm5} : {25'd0, imm5, 2'b00};
      end else if (op[15:12] == 4'b1000) begin
         add_b = {26'd0, imm5, 1'b0};
      end else if (op[15:12] == 4'b1001) begin
         add_a = req_chan.sp_value;
         add_b = {22'd0, imm8, 2'b00};
      end
   end

   assign addr_sum = add_a + add_b;

   // Format decode: access size, load kind and destination.
   always_comb begin
      item           = '0;
      item.addr      = addr_sum;
      item.dest      = op[2:0];
      item.size      = tlsu_pkg::SZ_WORD;
      item.load_kind = tlsu_pkg::LK_WORD;
      item.is_legal  = 1'b1;
      if (req_chan.req_type) begin
         item.is_return = 1'b1;
      end else if (op[15:11] == 5'b01001) begin
         item.is_load = 1'b1;
         item.dest    = op[10:8];
      end else if (op[15:12] == 4'b0101) begin
         if (!op[9]) begin
            item.is_load = op[11];
            if (op[10]) begin
               item.size      = tlsu_pkg::SZ_BYTE;
               item.load_kind = tlsu_pkg::LK_BYTE;
            end
         end else if (!op[10]) begin
            item.is_load   = op[11];
            item.size      = tlsu_pkg::SZ_HALF;
            item.load_kind = tlsu_pkg::LK_HALF;
         end else if (!op[11] || addr_sum[0]) begin
            // A signed halfword from an odd address is done as a signed byte.
            item.is_load   = 1'b1;
            item.size      = tlsu_pkg::SZ_BYTE;
            item.load_kind = tlsu_pkg::LK_SBYTE;
         end else begin
            item.is_load   = 1'b1;
            item.size      = tlsu_pkg::SZ_HALF;
            item.load_kind = tlsu_pkg::LK_SHALF;
         end
      end else if (op[15:13] == 3'b011) begin
         item.is_load = op[11];
         if (op[12]) begin
            item.size      = tlsu_pkg::SZ_BYTE;
            item.load_kind = tlsu_pkg::LK_BYTE;
         end
      end else if (op[15:12] == 4'b1000) begin
         item.is_load   = op[11];
         item.size      = tlsu_pkg::SZ_HALF;
         item.load_kind = tlsu_pkg::LK_HALF;
      end else if (op[15:12] == 4'b1001) begin
         item.is_load = op[11];
         item.dest    = op[10:8];
      end else begin
         item.is_legal = 1'b0;
      end

      // A return carries read data; store data is masked to the access size.
      if (req_chan.req_type) begin
         item.data = req_chan.read_data;
      end else begin
         case (item.size)
            tlsu_pkg::SZ_BYTE: item.data = {24'd0, req_chan.data_value[7:0]};
            tlsu_pkg::SZ_HALF: item.data = {16'd0, req_chan.data_value[15:0]};
            default:           item.data = req_chan.data_value;
         endcase
      end
   end

endmodule

/* design/tlsu_queue.sv */
`timescale 1ns / 1ps

module tlsu_queue #(
   parameter int Depth = tlsu_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  tlsu_pkg::fe_item_type push_item,
   output logic                  head_valid,
   input  logic                  pop,
   output tlsu_pkg::fe_item_type head_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   tlsu_pkg::fe_item_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* design/tlsu_back.sv */
`timescale 1ns / 1ps

module tlsu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  tlsu_pkg::fe_item_type  head_item,
   output logic                   pop,
   output tlsu_pkg::bk_status_type status,
   tlsu_rsp_if.source             rsp_chan
);

   logic                      pending_ff;
   logic                      pending_in;
   logic [2:0]                pend_dest_ff;
   logic [2:0]                pend_dest_in;
   tlsu_pkg::load_kind_type   pend_kind_ff;
   tlsu_pkg::load_kind_type   pend_kind_in;
   logic [1:0]                pend_low_ff;
   logic [1:0]                pend_low_in;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   tlsu_pkg::result_kind_type rsp_kind_ff;
   tlsu_pkg::result_kind_type rsp_kind_in;
   logic [31:0]               rsp_addr_ff;
   logic [31:0]               rsp_addr_in;
   logic [1:0]                rsp_size_ff;
   logic [1:0]                rsp_size_in;
   logic [31:0]               rsp_wdata_ff;
   logic [31:0]               rsp_wdata_in;
   logic [2:0]                rsp_dest_ff;
   logic [2:0]                rsp_dest_in;
   logic [31:0]               rsp_value_ff;
   logic [31:0]               rsp_value_in;

   logic [31:0]               load_value;
   logic [31:0]               rd;

   // Take the queue head when the output register is empty or drains now.
   assign pop = head_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_kind_ff;
   assign rsp_chan.mem_address = rsp_addr_ff;
   assign rsp_chan.access_size = rsp_size_ff;
   assign rsp_chan.write_data  = rsp_wdata_ff;
   assign rsp_chan.dest_reg    = rsp_dest_ff;
   assign rsp_chan.reg_value   = rsp_value_ff;

   assign rd = head_item.data;

   // Align, rotate or extend the returned data for the pending load.
   always_comb begin
      case (pend_kind_ff)
         tlsu_pkg::LK_WORD: begin
            case (pend_low_ff)
               2'd1:    load_value = {rd[7:0], rd[31:8]};
               2'd2:    load_value = {rd[15:0], rd[31:16]};
               2'd3:    load_value = {rd[23:0], rd[31:24]};
               default: load_value = rd;
            endcase
         end
         tlsu_pkg::LK_HALF: begin
            load_value = pend_low_ff[0] ? {rd[7:0], 16'd0, rd[15:8]} : {16'd0, rd[15:0]};
         end
         tlsu_pkg::LK_BYTE:  load_value = {24'd0, rd[7:0]};
         tlsu_pkg::LK_SBYTE: load_value = {{24{rd[7]}}, rd[7:0]};
         default:            load_value = {{16{rd[15]}}, rd[15:0]};
      endcase
   end

   // Execute the head item against the pending-load state.
   always_comb begin
      pending_in   = pending_ff;
      pend_dest_in = pend_dest_ff;
      pend_kind_in = pend_kind_ff;
      pend_low_in  = pend_low_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_wdata_in = rsp_wdata_ff;
      rsp_dest_in  = rsp_dest_ff;
      rsp_value_in = rsp_value_ff;
      status       = '0;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = tlsu_pkg::RK_ERR;
         rsp_addr_in  = '0;
         rsp_size_in  = '0;
         rsp_wdata_in = '0;
         rsp_dest_in  = '0;
         rsp_value_in = '0;
         if (head_item.is_return) begin
            if (pending_ff) begin
               rsp_kind_in      = tlsu_pkg::RK_WB;
               rsp_dest_in      = pend_dest_ff;
               rsp_value_in     = load_value;
               pending_in       = 1'b0;
               status.load_done = 1'b1;
            end
         end else if (!pending_ff && head_item.is_legal) begin
            rsp_addr_in = head_item.addr;
            rsp_size_in = head_item.size;
            if (head_item.is_load) begin
               rsp_kind_in        = tlsu_pkg::RK_READ;
               pending_in         = 1'b1;
               pend_dest_in       = head_item.dest;
               pend_kind_in       = head_item.load_kind;
               pend_low_in        = head_item.addr[1:0];
               status.load_issued = 1'b1;
            end else begin
               rsp_kind_in  = tlsu_pkg::RK_WRITE;
               rsp_wdata_in = head_item.data;
            end
         end
      end
      status.pending = pending_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         pend_dest_ff <= '0;
         pend_kind_ff <= tlsu_pkg::LK_WORD;
         pend_low_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         pend_dest_ff <= pend_dest_in;
         pend_kind_ff <= pend_kind_in;
         pend_low_ff  <= pend_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers need no reset.
   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_wdata_ff <= rsp_wdata_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

/* design/thumb_load_store_unit.sv */
`timescale 1ns / 1ps

// Channel    Ports       Direction  Carries
// req_chan   req_chan.*  in         instruction issue or memory read-data return
// rsp_chan   rsp_chan.*  out        read request, write request, writeback or error
//
// One item is taken per cycle while the decode queue has room. An item that is
// taken is written into the decode queue and from there moves into the result
// register, from which its result is offered. The rate is set by the single
// address adder in the front and the one-entry result register in the back,
// which handle one item each per cycle while the result is not stalled.
// Reset is synchronous and clears the queue, the pending-load flag and the
// result valid. A stalled result holds in its register while the queue keeps
// taking items until it fills.

module thumb_load_store_unit #(
   parameter int QueueDepth = tlsu_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   tlsu_req_if.sink   req_chan,
   tlsu_rsp_if.source rsp_chan
);

   logic                    push_valid;
   logic                    push_ready;
   tlsu_pkg::fe_item_type   push_item;
   logic                    head_valid;
   logic                    q_pop;
   tlsu_pkg::fe_item_type   head_item;
   tlsu_pkg::bk_status_type bk_status;

   // Decode and address generation.
   tlsu_front u_front (
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // Short queue between decode and execute.
   tlsu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .head_valid (head_valid),
      .pop        (q_pop),
      .head_item  (head_item)
   );

   // Load/store execution and result register.
   tlsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (q_pop),
      .status     (bk_status),
      .rsp_chan   (rsp_chan)
   );

   // An issued load leaves a pending load behind.
   assert property (@(posedge clock) disable iff (reset)
      bk_status.load_issued |=> bk_status.pending)
      else $error("load issued but no load pending");

   // A completed load clears the pending flag.
   assert property (@(posedge clock) disable iff (reset)
      bk_status.load_done |=> !bk_status.pending)
      else $error("pending flag still set after writeback");

   // A new load is never issued over a pending one.
   assert property (@(posedge clock) disable iff (reset)
      bk_status.load_issued |-> !bk_status.pending)
      else $error("load issued while another is pending");

   // The back only takes an item that the queue holds.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> head_valid)
      else $error("queue popped while empty");

endmodule

/* dv/tlsu_tb_pkg.sv */
`timescale 1ns / 1ps

package tlsu_tb_pkg;

   // Leading opcode bits of the Thumb load/store formats.
   localparam logic [4:0] OP_PC_LOAD    = 5'b01001;
   localparam logic [3:0] OP_REG_OFFSET = 4'b0101;
   localparam logic [2:0] OP_IMM_OFFSET = 3'b011;
   localparam logic [3:0] OP_HALF_IMM   = 4'b1000;
   localparam logic [3:0] OP_SP_REL     = 4'b1001;

endpackage

/* dv/tlsu_result_compare.sv */
`timescale 1ns / 1ps

module tlsu_result_compare (
   input  logic clock,
   input  logic reset,
   tlsu_req_if  req_chan,
   tlsu_rsp_if  rsp_chan,
   output int   fail_count,
   output int   outstanding,
   output int   reads_seen,
   output int   writes_seen,
   output int   writebacks_seen,
   output int   errors_seen
);

   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      tlsu_pkg::result_kind_type kind;
      logic [31:0]               address;
      tlsu_pkg::access_size_type size;
      logic [31:0]               store_data;
      logic [2:0]                dest;
      logic [31:0]               value;
   } lsu_result_type;

   // Our own copy of the outstanding-load state.
   logic                    load_waiting;
   logic [2:0]              waiting_dest;
   tlsu_pkg::load_kind_type waiting_kind;
   logic [1:0]              waiting_low;

   lsu_result_type lsu_results_due[$];
   lsu_result_type oldest;

   // Align, rotate or extend returned memory data for the waiting load.
   function automatic logic [31:0] shape_load_data(input logic [31:0] raw);
      logic [63:0] spun;
      logic [15:0] half;
      half = raw[15:0];
      case (waiting_kind)
         tlsu_pkg::LK_WORD: begin
            spun = {raw, raw} >> {waiting_low, 3'b000};
            return spun[31:0];
         end
         tlsu_pkg::LK_HALF: begin
            if (waiting_low[0]) begin
               return {half[7:0], 16'h0000, half[15:8]};
            end
            return {16'h0000, half};
         end
         tlsu_pkg::LK_BYTE: return {24'h000000, raw[7:0]};
         tlsu_pkg::LK_SBYTE: return {{24{raw[7]}}, raw[7:0]};
         default: return {{16{raw[15]}}, raw[15:0]};
      endcase
   endfunction

   // Work out the result of one accepted item and advance the load state.
   function automatic lsu_result_type execute_lsu_item(
      input logic        is_return,
      input logic [15:0] op,
      input logic [31:0] rb,
      input logic [31:0] ro,
      input logic [31:0] rdv,
      input logic [31:0] pc,
      input logic [31:0] sp,
      input logic [31:0] raw
   );
      lsu_result_type            res;
      logic [31:0]               addr;
      logic                      is_load;
      logic                      legal;
      tlsu_pkg::access_size_type sz;
      tlsu_pkg::load_kind_type   kind;
      logic [2:0]                rd;

      res = '0;
      res.kind = tlsu_pkg::RK_ERR;

      // A read-data item completes the waiting load, if there is one.
      if (is_return) begin
         if (load_waiting) begin
            res.kind = tlsu_pkg::RK_WB;
            res.dest = waiting_dest;
            res.value = shape_load_data(raw);
            load_waiting = 1'b0;
         end
         return res;
      end
      if (load_waiting) begin
         return res;
      end

      legal = 1'b1;
      is_load = op[11];
      rd = op[2:0];
      sz = tlsu_pkg::SZ_WORD;
      kind = tlsu_pkg::LK_WORD;
      addr = '0;

      // Decode the format and form the effective address.
      if (op[15:11] == tlsu_tb_pkg::OP_PC_LOAD) begin
         addr = (pc & tlsu_pkg::PC_ALIGN_MASK) + {22'd0, op[7:0], 2'b00};
         is_load = 1'b1;
         rd = op[10:8];
      end else if (op[15:12] == tlsu_tb_pkg::OP_REG_OFFSET) begin
         addr = rb + ro;
         if (!op[9]) begin
            if (op[10]) begin
               sz = tlsu_pkg::SZ_BYTE;
               kind = tlsu_pkg::LK_BYTE;
            end
         end else if (!op[10]) begin
            sz = tlsu_pkg::SZ_HALF;
            kind = tlsu_pkg::LK_HALF;
         end else begin
            // Sign-extending loads; a halfword from an odd address is a byte.
            is_load = 1'b1;
            if (!op[11] || addr[0]) begin
               sz = tlsu_pkg::SZ_BYTE;
               kind = tlsu_pkg::LK_SBYTE;
            end else begin
               sz = tlsu_pkg::SZ_HALF;
               kind = tlsu_pkg::LK_SHALF;
            end
         end
      end else if (op[15:13] == tlsu_tb_pkg::OP_IMM_OFFSET) begin
         if (op[12]) begin
            addr = rb + {27'd0, op[10:6]};
            sz = tlsu_pkg::SZ_BYTE;
            kind = tlsu_pkg::LK_BYTE;
         end else begin
            addr = rb + {25'd0, op[10:6], 2'b00};
         end
      end else if (op[15:12] == tlsu_tb_pkg::OP_HALF_IMM) begin
         addr = rb + {26'd0, op[10:6], 1'b0};
         sz = tlsu_pkg::SZ_HALF;
         kind = tlsu_pkg::LK_HALF;
      end else if (op[15:12] == tlsu_tb_pkg::OP_SP_REL) begin
         addr = sp + {22'd0, op[7:0], 2'b00};
         rd = op[10:8];
      end else begin
         legal = 1'b0;
      end

      if (!legal) begin
         return res;
      end
      res.address = addr;
      res.size = sz;
      if (is_load) begin
         res.kind = tlsu_pkg::RK_READ;
         load_waiting = 1'b1;
         waiting_dest = rd;
         waiting_kind = kind;
         waiting_low = addr[1:0];
      end else begin
         res.kind = tlsu_pkg::RK_WRITE;
         case (sz)
            tlsu_pkg::SZ_BYTE: res.store_data = {24'h000000, rdv[7:0]};
            tlsu_pkg::SZ_HALF: res.store_data = {16'h0000, rdv[15:0]};
            default: res.store_data = rdv;
         endcase
      end
      return res;
   endfunction

   // Print one line per mismatch, up to a limit, and count every one.
   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("[%0t] %s: got 0x%08h, expected 0x%08h", $time, field, got, want);
      end
   endtask

   // Compare each result leaving the block, then predict each new item.
   always @(posedge clock) begin
      if (reset) begin
         load_waiting = 1'b0;
         waiting_dest = '0;
         waiting_kind = tlsu_pkg::LK_WORD;
         waiting_low = '0;
         lsu_results_due.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            case (rsp_chan.result_kind)
               tlsu_pkg::RK_READ: reads_seen++;
               tlsu_pkg::RK_WRITE: writes_seen++;
               tlsu_pkg::RK_WB: writebacks_seen++;
               default: errors_seen++;
            endcase
            if (lsu_results_due.size() == 0) begin
               report_mismatch("result with none expected, kind",
                               32'(rsp_chan.result_kind), 32'(tlsu_pkg::RK_ERR));
            end else begin
               oldest = lsu_results_due.pop_front();
               if (rsp_chan.result_kind != oldest.kind) begin
                  report_mismatch("result_kind", 32'(rsp_chan.result_kind),
                                  32'(oldest.kind));
               end
               if (rsp_chan.mem_address != oldest.address) begin
                  report_mismatch("mem_address", rsp_chan.mem_address, oldest.address);
               end
               if (rsp_chan.access_size != oldest.size) begin
                  report_mismatch("access_size", 32'(rsp_chan.access_size),
                                  32'(oldest.size));
               end
               if (rsp_chan.write_data != oldest.store_data) begin
                  report_mismatch("write_data", rsp_chan.write_data, oldest.store_data);
               end
               if (rsp_chan.dest_reg != oldest.dest) begin
                  report_mismatch("dest_reg", 32'(rsp_chan.dest_reg), 32'(oldest.dest));
               end
               if (rsp_chan.reg_value != oldest.value) begin
                  report_mismatch("reg_value", rsp_chan.reg_value, oldest.value);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            lsu_results_due.push_back(execute_lsu_item(
               req_chan.req_type, req_chan.opcode, req_chan.base_value,
               req_chan.index_value, req_chan.data_value, req_chan.pc_value,
               req_chan.sp_value, req_chan.read_data));
         end
      end
      outstanding <= lsu_results_due.size();
   end

endmodule

/* dv/tb_thumb_load_store_unit.sv */
`timescale 1ns / 1ps

module tb_thumb_load_store_unit;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES   = 10;

   logic clock;
   logic reset;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int holds_started;
   int hold_left;
   int items_sent;
   int quiet_cycles;

   int fail_count;
   int outstanding;
   int reads_seen;
   int writes_seen;
   int writebacks_seen;
   int errors_seen;

   tlsu_req_if req_chan ();
   tlsu_rsp_if rsp_chan ();

   thumb_load_store_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tlsu_result_compare u_compare (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .reads_seen      (reads_seen),
      .writes_seen     (writes_seen),
      .writebacks_seen (writebacks_seen),
      .errors_seen     (errors_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (holds_started != hold_requests) begin
            holds_started <= holds_started + 1;
            hold_left <= HOLD_OFF_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: give up once nothing has moved on either channel for too long.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] reg_op(input bit ld, input bit byte_sel, input bit sign_sel,
                                          input logic [2:0] ro, input logic [2:0] rb,
                                          input logic [2:0] rd);
      return {tlsu_tb_pkg::OP_REG_OFFSET, ld, byte_sel, sign_sel, ro, rb, rd};
   endfunction

   function automatic logic [15:0] imm_op(input bit byte_sel, input bit ld,
                                          input logic [4:0] imm5, input logic [2:0] rb,
                                          input logic [2:0] rd);
      return {tlsu_tb_pkg::OP_IMM_OFFSET, byte_sel, ld, imm5, rb, rd};
   endfunction

   function automatic logic [15:0] half_op(input bit ld, input logic [4:0] imm5,
                                           input logic [2:0] rb, input logic [2:0] rd);
      return {tlsu_tb_pkg::OP_HALF_IMM, ld, imm5, rb, rd};
   endfunction

   function automatic logic [15:0] sp_op(input bit ld, input logic [2:0] rd,
                                         input logic [7:0] imm8);
      return {tlsu_tb_pkg::OP_SP_REL, ld, rd, imm8};
   endfunction

   // A random opcode from one of the load/store formats; tells whether it loads.
   function automatic logic [15:0] make_transfer(output bit is_load);
      logic [15:0] op;
      case ($urandom_range(4))
         0: op = {tlsu_tb_pkg::OP_PC_LOAD, 11'($urandom())};
         1: op = {tlsu_tb_pkg::OP_REG_OFFSET, 12'($urandom())};
         2: op = {tlsu_tb_pkg::OP_IMM_OFFSET, 13'($urandom())};
         3: op = {tlsu_tb_pkg::OP_HALF_IMM, 12'($urandom())};
         default: op = {tlsu_tb_pkg::OP_SP_REL, 12'($urandom())};
      endcase
      if (op[15:11] == tlsu_tb_pkg::OP_PC_LOAD) begin
         is_load = 1'b1;
      end else if (op[15:12] == tlsu_tb_pkg::OP_REG_OFFSET) begin
         is_load = op[11] | (op[10] & op[9]);
      end else begin
         is_load = op[11];
      end
      return op;
   endfunction

   // Offer one item and wait until the block takes it.
   task automatic send_item(input logic is_return, input logic [15:0] op,
                            input logic [31:0] rb, input logic [31:0] ro,
                            input logic [31:0] rdv, input logic [31:0] pc,
                            input logic [31:0] sp, input logic [31:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= is_return;
      req_chan.opcode <= op;
      req_chan.base_value <= rb;
      req_chan.index_value <= ro;
      req_chan.data_value <= rdv;
      req_chan.pc_value <= pc;
      req_chan.sp_value <= sp;
      req_chan.read_data <= raw;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic issue(input logic [15:0] op, input logic [31:0] rb, input logic [31:0] ro,
                        input logic [31:0] rdv, input logic [31:0] pc,
                        input logic [31:0] sp);
      send_item(1'b0, op, rb, ro, rdv, pc, sp, rand_word());
   endtask

   task automatic give_back(input logic [31:0] raw);
      send_item(1'b1, 16'($urandom()), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word(), raw);
   endtask

   // Stop offering and wait until every expected result has left the block.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Mostly complete transfers with random content, some protocol misuse.
   task automatic run_mix(input int count);
      int          stop;
      int          pick;
      bit          ld;
      logic [15:0] op;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 82) begin
            op = make_transfer(ld);
            issue(op, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
            if (ld) begin
               give_back(rand_word());
            end
         end else if (pick < 88) begin
            // Read data that no load asked for.
            give_back(rand_word());
         end else if (pick < 94) begin
            // A second instruction while a load still waits for its data.
            do op = make_transfer(ld); while (!ld);
            issue(op, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
            issue(make_transfer(ld), rand_word(), rand_word(), rand_word(), rand_word(),
                  rand_word());
            give_back(rand_word());
         end else begin
            // Any instruction word, then a return that either closes it or is stray.
            issue(16'($urandom()), rand_word(), rand_word(), rand_word(), rand_word(),
                  rand_word());
            give_back(rand_word());
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.req_type <= 1'b0;
      req_chan.opcode <= '0;
      req_chan.base_value <= '0;
      req_chan.index_value <= '0;
      req_chan.data_value <= '0;
      req_chan.pc_value <= '0;
      req_chan.sp_value <= '0;
      req_chan.read_data <= '0;
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: every format, the field extremes and the misuse cases.
      give_back(32'h1234_5678);
      issue({tlsu_tb_pkg::OP_PC_LOAD, 3'd7, 8'hFF}, '0, '0, '0, 32'hFFFF_FFFF, '0);
      give_back(32'hDEAD_BEEF);
      issue(reg_op(1'b1, 1'b0, 1'b0, 3'd1, 3'd2, 3'd3), 32'd1, 32'd2, '0, '0, '0);
      give_back(32'h1122_3344);
      issue(reg_op(1'b1, 1'b1, 1'b0, 3'd7, 3'd7, 3'd7), 32'hFFFF_FFFF, 32'd2, '0, '0, '0);
      give_back(32'hFFFF_FFFF);
      issue(reg_op(1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 3'd0), '0, '0, 32'hFFFF_FFFF, '0, '0);
      issue(reg_op(1'b0, 1'b0, 1'b1, 3'd4, 3'd5, 3'd6), 32'd6, 32'd1, 32'hFFFF_FFFF, '0, '0);
      issue(reg_op(1'b1, 1'b0, 1'b1, 3'd1, 3'd1, 3'd4), 32'd1, '0, '0, '0, '0);
      give_back(32'hABCD_1234);
      issue(reg_op(1'b0, 1'b1, 1'b1, 3'd2, 3'd3, 3'd5), '0, '0, '0, '0, '0);
      give_back(32'h0000_0080);
      issue(reg_op(1'b1, 1'b1, 1'b1, 3'd3, 3'd4, 3'd6), 32'd2, '0, '0, '0, '0);
      give_back(32'h0000_8000);
      issue(reg_op(1'b1, 1'b1, 1'b1, 3'd5, 3'd6, 3'd7), 32'd3, '0, '0, '0, '0);
      give_back(32'h0000_807F);
      issue(imm_op(1'b0, 1'b1, 5'd31, 3'd7, 3'd1), 32'hFFFF_FFFF, '0, '0, '0, '0);
      issue(imm_op(1'b1, 1'b0, 5'd0, 3'd0, 3'd0), '0, '0, 32'hFFFF_FFFF, '0, '0);
      give_back(32'h8000_0001);
      issue(imm_op(1'b1, 1'b0, 5'd31, 3'd2, 3'd3), 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, '0, '0);
      issue(half_op(1'b1, 5'd31, 3'd1, 3'd2), '0, '0, '0, '0, '0);
      give_back(32'hFFFF_FFFF);
      issue(half_op(1'b0, 5'd31, 3'd0, 3'd7), 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, '0, '0);
      issue(sp_op(1'b1, 3'd7, 8'hFF), '0, '0, '0, '0, 32'hFFFF_FFFF);
      give_back(32'h0123_4567);
      issue(sp_op(1'b0, 3'd0, 8'h00), '0, '0, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
      issue(16'h0000, '0, '0, '0, '0, '0);
      issue(16'hFFFF, '0, '0, '0, '0, '0);
      wait_drained();

      // Light sender gaps against a heavily stalling receiver.
      send_idle_pct = 7;
      recv_idle_pct <= 82;
      run_mix(450);
      wait_drained();

      // The other way round.
      send_idle_pct = 82;
      recv_idle_pct <= 7;
      run_mix(450);
      wait_drained();

      // Full rate, with one long receiver hold-off so the block backs up.
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      run_mix(100);
      hold_requests <= hold_requests + 1;
      run_mix(400);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items; results: %0d reads, %0d writes, %0d writebacks, %0d errors.",
               items_sent, reads_seen, writes_seen, writebacks_seen, errors_seen);
      $display("Ran sender-light, receiver-light and unthrottled mixes with a long hold-off.");
      if (outstanding != 0) begin
         $display("%0d expected results never arrived", outstanding);
      end
      if (fail_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
